// ===== rtl/rlcbs_pkg.sv =====
// Package for the RGB LED chain bit serializer.
// Opcodes, register indexes, reset values, FSM state and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package rlcbs_pkg;

  // Default chain length (LEDs)
  localparam int DEF_CHAIN_LENGTH = 64;

  // One GRB pixel row
  localparam int PIXEL_W = 24;
  localparam int BITPOS_W = 5;

  // Input opcodes
  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_SHOW = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] CFG_ZERO_IDX = 1'b0;
  localparam logic [0:0] CFG_ONE_IDX  = 1'b1;

  // Duty register reset values
  localparam logic [7:0] ZERO_DUTY_RST = 8'd37;
  localparam logic [7:0] ONE_DUTY_RST  = 8'd8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_TICK_RD
  } state_t;

  // Duty codes handed from the register file to the controller
  typedef struct packed {
    logic [7:0] zero_duty;
    logic [7:0] one_duty;
  } duty_cfg_t;

  // One result item
  typedef struct packed {
    logic       accepted;
    logic       duty_valid;
    logic [7:0] duty_code;
    logic       finished;
    logic       busy;
  } res_t;

  // Result load request from the controller to the output register
  typedef struct packed {
    logic load;
    res_t res;
  } res_load_t;

endpackage

// ===== rtl/rlcbs_pixel_mem.sv =====
// Pixel store: one 24-bit GRB row per LED, one write and one read port.
// Read data is registered. Uses rlcbs_pkg.
`timescale 1ns / 1ps

module rlcbs_pixel_mem #(
  parameter int CHAIN_LENGTH = rlcbs_pkg::DEF_CHAIN_LENGTH,
  localparam int ADDR_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [ADDR_W-1:0]            waddr,
  input  logic [rlcbs_pkg::PIXEL_W-1:0] wdata,
  input  logic                         re,
  input  logic [ADDR_W-1:0]            raddr,
  output logic [rlcbs_pkg::PIXEL_W-1:0] rdata
);
  import rlcbs_pkg::*;

  logic [PIXEL_W-1:0] mem [CHAIN_LENGTH];
  logic [PIXEL_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rlcbs_ctrl.sv =====
// Controller: item decode, stream counters, fill and clear sweeps, and the
// read-then-serialize step for ticks. Drives the pixel memory. Uses rlcbs_pkg.
`timescale 1ns / 1ps

module rlcbs_ctrl #(
  parameter int CHAIN_LENGTH = rlcbs_pkg::DEF_CHAIN_LENGTH,
  localparam int ADDR_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_led_index,
  input  logic [7:0]                    in_red_level,
  input  logic [7:0]                    in_green_level,
  input  logic [7:0]                    in_blue_level,
  input  logic [7:0]                    in_show_count,
  input  logic                          out_free,
  input  rlcbs_pkg::duty_cfg_t          duty_cfg,
  output rlcbs_pkg::res_load_t          res_load,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_waddr,
  output logic [rlcbs_pkg::PIXEL_W-1:0] mem_wdata,
  output logic                          mem_re,
  output logic [ADDR_W-1:0]             mem_raddr,
  input  logic [rlcbs_pkg::PIXEL_W-1:0] mem_rdata
);
  import rlcbs_pkg::*;

  // Largest LED count a show can request (count field is 8 bits)
  localparam int MAX_SHOW = (CHAIN_LENGTH < 255) ? CHAIN_LENGTH : 255;
  localparam int LED_CNT_W = $clog2(MAX_SHOW + 1);
  localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(CHAIN_LENGTH - 1);
  localparam logic [BITPOS_W-1:0] LAST_BIT = BITPOS_W'(PIXEL_W - 1);

  state_t               state_r, state_nxt;
  logic                 streaming_r, streaming_nxt;
  logic [LED_CNT_W-1:0] led_ptr_r, led_ptr_nxt;
  logic [LED_CNT_W-1:0] led_count_r, led_count_nxt;
  logic [BITPOS_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic [ADDR_W-1:0]    sweep_r, sweep_nxt;
  logic [PIXEL_W-1:0]   fill_data_r, fill_data_nxt;

  logic       in_take;
  logic       data_bit;
  logic [7:0] show_sat;

  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_take  = in_valid && !in_stall;
  assign show_sat = (in_show_count > 8'(MAX_SHOW)) ? 8'(MAX_SHOW) : in_show_count;
  assign data_bit = mem_rdata[LAST_BIT - bit_pos_r];

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      streaming_r <= 1'b0;
      led_ptr_r   <= '0;
      led_count_r <= '0;
      bit_pos_r   <= '0;
      sweep_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      streaming_r <= streaming_nxt;
      led_ptr_r   <= led_ptr_nxt;
      led_count_r <= led_count_nxt;
      bit_pos_r   <= bit_pos_nxt;
      sweep_r     <= sweep_nxt;
    end
  end

  // Fill color, payload only
  always_ff @(posedge clk) begin
    fill_data_r <= fill_data_nxt;
  end

  // Next state, memory control and result load
  always_comb begin
    state_nxt     = state_r;
    streaming_nxt = streaming_r;
    led_ptr_nxt   = led_ptr_r;
    led_count_nxt = led_count_r;
    bit_pos_nxt   = bit_pos_r;
    sweep_nxt     = sweep_r;
    fill_data_nxt = fill_data_r;
    mem_we        = 1'b0;
    mem_waddr     = sweep_r;
    mem_wdata     = fill_data_r;
    mem_re        = 1'b0;
    mem_raddr     = ADDR_W'(led_ptr_r);
    res_load      = '0;

    case (state_r)
      // Zero the store after reset, one row a cycle
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (sweep_r == LAST_ROW) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      // Write the fill color into every row
      ST_FILL: begin
        mem_we = 1'b1;
        if (sweep_r == LAST_ROW) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end

      // Row data is back: emit the duty for the current bit, MSB first
      ST_TICK_RD: begin
        res_load.load           = 1'b1;
        res_load.res.duty_valid = 1'b1;
        res_load.res.duty_code  = data_bit ? duty_cfg.one_duty : duty_cfg.zero_duty;
        res_load.res.busy       = 1'b1;
        if (bit_pos_r == LAST_BIT) begin
          bit_pos_nxt = '0;
          led_ptr_nxt = LED_CNT_W'(led_ptr_r + 1'b1);
        end else begin
          bit_pos_nxt = bit_pos_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_take) begin
          case (in_opcode)
            OP_SET: begin
              res_load.load     = 1'b1;
              res_load.res.busy = streaming_r;
              if (!streaming_r) begin
                if (in_led_index == 8'd0) begin
                  fill_data_nxt         = {in_green_level, in_red_level, in_blue_level};
                  sweep_nxt             = '0;
                  state_nxt             = ST_FILL;
                  res_load.res.accepted = 1'b1;
                end else if ({24'd0, in_led_index} <= 32'(CHAIN_LENGTH)) begin
                  mem_we                = 1'b1;
                  mem_waddr             = ADDR_W'(in_led_index - 8'd1);
                  mem_wdata             = {in_green_level, in_red_level, in_blue_level};
                  res_load.res.accepted = 1'b1;
                end
              end
            end

            OP_SHOW: begin
              res_load.load     = 1'b1;
              res_load.res.busy = 1'b1;
              if (!streaming_r) begin
                led_count_nxt         = LED_CNT_W'(show_sat);
                led_ptr_nxt           = '0;
                bit_pos_nxt           = '0;
                streaming_nxt         = 1'b1;
                res_load.res.accepted = 1'b1;
              end
            end

            OP_TICK: begin
              if (streaming_r && (led_ptr_r < led_count_r)) begin
                mem_re    = 1'b1;
                state_nxt = ST_TICK_RD;
              end else begin
                res_load.load = 1'b1;
                if (streaming_r) begin
                  // all bits sent: end of stream
                  res_load.res.finished = 1'b1;
                  streaming_nxt         = 1'b0;
                  led_ptr_nxt           = '0;
                  bit_pos_nxt           = '0;
                end
              end
            end

            default: begin
              res_load.load     = 1'b1;
              res_load.res.busy = streaming_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rgb_led_chain_bit_serializer_core.sv =====
// Top level of the RGB LED chain bit serializer: duty registers, result
// register, controller and pixel memory. Uses rlcbs_pkg, rlcbs_ctrl, rlcbs_pixel_mem.
`timescale 1ns / 1ps

//  Channel  Ports                                   Transfer when
//  in       in_valid/in_stall, opcode..show_count  in_valid && !in_stall
//  out      out_valid/out_stall, accepted..busy    out_valid && !out_stall
//  cfg      cfg_we, cfg_index, cfg_data            cfg_we
//
//  Set one LED, show, other ticks and no-ops load their result from ST_IDLE;
//  fill-all writes one memory row per cycle in ST_FILL; a tick that emits
//  a bit reads the pixel memory in ST_IDLE and loads its result in ST_TICK_RD.
//  After reset a clearing pass writes zero to every row of the store
//  with in_stall high; cfg writes are taken during it.
//  A result waits in the output register while out_stall is high; the next
//  item is taken as soon as that register drains in the same cycle.

module rgb_led_chain_bit_serializer_core #(
  parameter int CHAIN_LENGTH = rlcbs_pkg::DEF_CHAIN_LENGTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_led_index,
  input  logic [7:0] in_red_level,
  input  logic [7:0] in_green_level,
  input  logic [7:0] in_blue_level,
  input  logic [7:0] in_show_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_accepted,
  output logic       out_duty_valid,
  output logic [7:0] out_duty_code,
  output logic       out_finished,
  output logic       out_busy_res,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import rlcbs_pkg::*;

  localparam int ADDR_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;

  logic [7:0]         zero_duty_r;
  logic [7:0]         one_duty_r;
  logic               out_valid_r;
  res_t               out_res_r;
  logic               out_free;
  duty_cfg_t          duty_cfg;
  res_load_t          res_load;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [PIXEL_W-1:0] mem_rdata;

  // Duty code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_duty_r <= ZERO_DUTY_RST;
      one_duty_r  <= ONE_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZERO_IDX: zero_duty_r <= cfg_data;
        CFG_ONE_IDX:  one_duty_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign duty_cfg.zero_duty = zero_duty_r;
  assign duty_cfg.one_duty  = one_duty_r;

  // Output register: free when empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load.load) begin
      out_res_r <= res_load.res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_res_r.accepted;
  assign out_duty_valid = out_res_r.duty_valid;
  assign out_duty_code  = out_res_r.duty_code;
  assign out_finished   = out_res_r.finished;
  assign out_busy_res   = out_res_r.busy;

  rlcbs_ctrl #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_led_index  (in_led_index),
    .in_red_level  (in_red_level),
    .in_green_level(in_green_level),
    .in_blue_level (in_blue_level),
    .in_show_count (in_show_count),
    .out_free      (out_free),
    .duty_cfg      (duty_cfg),
    .res_load      (res_load),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  rlcbs_pixel_mem #(
    .CHAIN_LENGTH(CHAIN_LENGTH)
  ) u_pixel_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
